// ===== rtl/core/psu_pkg.sv =====
// ============================================================================
// psu_pkg
// Shared types and constants of the particle state update block.
// ============================================================================
package psu_pkg;

    localparam int MaxParticles = 1024;
    localparam int CntW = 11;
    localparam logic [CntW-1:0] CntCap =
        CntW'((MaxParticles > 2047) ? 2047 : MaxParticles);

    // input payload: 16+60+48+48+32+48+32+16+16+48 = 364 bits, 368 padded
    localparam int InDataW = 368;
    // output payload: 1+16+60+48+48+32+11 = 216 bits
    localparam int OutDataW = 216;

    // multiplier operand selects
    localparam logic [2:0] OP_FRIC = 3'd0;
    localparam logic [2:0] OP_DT2  = 3'd1;
    localparam logic [2:0] OP_POS  = 3'd2;
    localparam logic [2:0] OP_VEL  = 3'd3;
    localparam logic [2:0] OP_GRAV = 3'd4;
    localparam logic [2:0] OP_RAMP = 3'd5;

    typedef struct packed {
        logic       load;    // capture item and compute life
        logic       mul;     // run one multiply step
        logic [2:0] op;      // step kind
        logic [2:0] lane;    // component index (ramp: 0..2 color, 4 alpha, 5 size)
        logic       pos_fin; // position step uses stored v*m product
        logic       finish;  // update counter, present result
    } t_cmd;

    typedef struct packed {
        logic alive;
    } t_sts;

endpackage

// ===== rtl/core/psu_datapath.sv =====
// ============================================================================
// psu_datapath
// Particle arithmetic around one shared signed multiplier.
// ============================================================================
module psu_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [15:0]             i_frame_time,
    input  logic [psu_pkg::InDataW-1:0] i_data,
    input  psu_pkg::t_cmd           i_cmd,
    output psu_pkg::t_sts           o_sts,
    output logic [psu_pkg::OutDataW-1:0] o_data
);
    import psu_pkg::*;

    logic [59:0] r_pos;
    logic [47:0] r_vel, r_col, r_crate, r_grav;
    logic [31:0] r_as, r_asrate;
    logic [15:0] r_mass, r_fric;
    logic        r_last_unused;
    logic signed [15:0] r_nl;
    logic signed [33:0] r_factor;
    logic [31:0] r_dt2;
    logic signed [33:0] r_vm;
    logic [59:0] r_npos;
    logic [47:0] r_nvel, r_ncol;
    logic [31:0] r_nas;
    logic signed [49:0] r_vacc;
    logic [CntW-1:0] r_cnt, r_so_far;
    logic        r_alive;

    logic signed [34:0] m_a;
    logic signed [34:0] m_b;
    logic signed [69:0] m_p;
    logic signed [16:0] life_tmp;
    logic signed [16:0] lsat;
    logic signed [15:0] v_k, g_k, r_k, a_k;
    logic signed [19:0] p_k;
    logic signed [24:0] psum;
    logic signed [16:0] rsum;
    logic signed [50:0] vsum;

    function automatic logic signed [19:0] sat20(input logic signed [24:0] v);
        if (v > 25'sd524287) return 20'sh7FFFF;
        if (v < -25'sd524288) return 20'sh80000;
        return v[19:0];
    endfunction
    function automatic logic signed [15:0] sat16(input logic signed [50:0] v);
        if (v > 51'sd32767) return 16'sh7FFF;
        if (v < -51'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // life: floor((life*256 - dt)/256)
    always_comb begin
        life_tmp = 17'($signed(i_data[15:0])) - 17'(i_frame_time[15:8])
                 - ((i_frame_time[7:0] != 8'd0) ? 17'sd1 : 17'sd0);
        lsat = life_tmp;
        if (life_tmp < -17'sd32768) lsat = -17'sd32768;
    end

    // operand selection for the shared multiplier
    always_comb begin
        v_k = $signed(r_vel[16*i_cmd.lane[1:0] +: 16]);
        g_k = $signed(r_grav[16*i_cmd.lane[1:0] +: 16]);
        p_k = $signed(r_pos[20*i_cmd.lane[1:0] +: 20]);
        if (i_cmd.lane[2]) begin
            r_k = $signed(r_asrate[16*i_cmd.lane[0] +: 16]);
            a_k = $signed(r_as[16*i_cmd.lane[0] +: 16]);
        end else begin
            r_k = $signed(r_crate[16*i_cmd.lane[1:0] +: 16]);
            a_k = $signed(r_col[16*i_cmd.lane[1:0] +: 16]);
        end
        m_a = '0;
        m_b = '0;
        unique case (i_cmd.op)
            OP_FRIC: begin m_a = 35'({1'b0, r_fric});  m_b = 35'({1'b0, i_frame_time}); end
            OP_DT2:  begin m_a = 35'({1'b0, i_frame_time}); m_b = 35'({1'b0, i_frame_time}); end
            OP_POS: begin
                if (i_cmd.pos_fin) begin m_a = 35'(r_vm); m_b = 35'({1'b0, i_frame_time}); end
                else begin m_a = 35'(v_k); m_b = 35'({1'b0, r_mass}); end
            end
            OP_VEL:  begin m_a = 35'(v_k); m_b = 35'(r_factor); end
            OP_GRAV: begin m_a = 35'(g_k); m_b = 35'({1'b0, r_dt2}); end
            OP_RAMP: begin m_a = 35'(r_k); m_b = 35'({1'b0, i_frame_time}); end
            default: begin m_a = '0; m_b = '0; end
        endcase
        m_p = m_a * m_b;
        psum = 25'(p_k) + 25'(m_p >>> 24);
        rsum = 17'(a_k) + 17'(m_p >>> 16);
        vsum = 51'(r_vacc) + 51'(m_p >>> 32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.finish) begin
            if (r_alive) begin
                r_so_far <= (r_cnt < CntCap) ? r_cnt + 1'b1 : r_cnt;
                r_cnt    <= r_last_unused ? '0 : ((r_cnt < CntCap) ? r_cnt + 1'b1 : r_cnt);
            end else begin
                r_so_far <= r_cnt;
                if (r_last_unused) r_cnt <= '0;
            end
        end
    end

    // hold item, run multiply steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos         <= i_data[75:16];
            r_vel         <= i_data[123:76];
            r_col         <= i_data[171:124];
            r_as          <= i_data[203:172];
            r_crate       <= i_data[251:204];
            r_asrate      <= i_data[283:252];
            r_mass        <= i_data[299:284];
            r_fric        <= i_data[315:300];
            r_grav        <= i_data[363:316];
            r_last_unused <= i_data[364];
            r_nl          <= lsat[15:0];
            r_alive       <= lsat > 17'sd0;
            r_npos        <= i_data[75:16];
            r_nvel        <= i_data[123:76];
            r_ncol        <= i_data[171:124];
            r_nas         <= i_data[203:172];
        end else if (i_cmd.mul) begin
            unique case (i_cmd.op)
                OP_FRIC: r_factor <= 34'sd16777216 - 34'(m_p[33:0]);
                OP_DT2:  r_dt2 <= m_p[31:0];
                OP_POS: begin
                    if (i_cmd.pos_fin) r_npos[20*i_cmd.lane[1:0] +: 20] <= sat20(psum);
                    else r_vm <= 34'(m_p);
                end
                OP_VEL:  r_vacc <= 50'(m_p >>> 24);
                OP_GRAV: r_nvel[16*i_cmd.lane[1:0] +: 16] <= sat16(vsum);
                OP_RAMP: begin
                    if (i_cmd.lane[2])
                        r_nas[16*i_cmd.lane[0] +: 16] <= sat16(51'(rsum));
                    else
                        r_ncol[16*i_cmd.lane[1:0] +: 16] <= sat16(51'(rsum));
                end
                default: ;
            endcase
        end
    end

    assign o_sts.alive = r_alive;
    assign o_data = {r_so_far, r_nas, r_ncol, r_nvel, r_npos, r_nl, r_alive};

endmodule

// ===== rtl/core/psu_ctrl.sv =====
// ============================================================================
// psu_ctrl
// Sequencer: load, run the multiply steps of an alive item, present result.
// ============================================================================
module psu_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  psu_pkg::t_sts i_sts,
    output psu_pkg::t_cmd o_cmd
);
    import psu_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [4:0] r_step, n_step;

    // step schedule: 0 fric, 1 dt2, 2..7 pos (vm, fin) x3,
    // 8..13 vel/grav x3, 14..16 color ramps, 17 alpha, 18 size
    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        n_step = r_step;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_RUN;
                    n_step = '0;
                end
            end
            S_RUN: begin
                if (!i_sts.alive) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.mul = 1'b1;
                    if (r_step == 5'd0) o_cmd.op = OP_FRIC;
                    else if (r_step == 5'd1) o_cmd.op = OP_DT2;
                    else if (r_step < 5'd8) begin
                        o_cmd.op = OP_POS;
                        o_cmd.lane = 3'((r_step - 5'd2) >> 1);
                        o_cmd.pos_fin = r_step[0];
                    end else if (r_step < 5'd14) begin
                        o_cmd.op = r_step[0] ? OP_GRAV : OP_VEL;
                        o_cmd.lane = 3'((r_step - 5'd8) >> 1);
                    end else begin
                        o_cmd.op = OP_RAMP;
                        o_cmd.lane = (r_step < 5'd17) ? 3'(r_step - 5'd14)
                                                      : 3'(r_step - 5'd13);
                    end
                    n_step = r_step + 5'd1;
                    if (r_step == 5'd18) n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready = i_out_ready;
                if (i_out_ready) begin
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state = S_RUN;
                        n_step = '0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// ===== rtl/core/particle_state_update.sv =====
// ============================================================================
// particle_state_update
// Fixed-point Euler update of one particle per transaction.
// ============================================================================
// One particle per transaction: an alive particle runs 19 steps on the single
// shared 35x35 multiplier, then the finish and output states; a dead one
// skips the steps and goes straight to finish and output. The next item is
// accepted in the cycle its predecessor's result is taken.
// frame_time is written through i_cfg_we.
module particle_state_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [15:0]                   i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // life_left, position_xyz, velocity_xyz, color_rgb, alpha_and_size,
    // color_rate, alpha_size_rate, mass_factor, friction_factor, gravity_xyz
    input  logic [psu_pkg::InDataW-1:0]   s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // alive, new_life, new_position, new_velocity, new_color,
    // new_alpha_size, alive_so_far
    output logic [psu_pkg::OutDataW-1:0]  m_axis_tdata
);
    import psu_pkg::*;

    logic [15:0] r_frame_time;
    t_cmd cmd;
    t_sts sts;
    logic [InDataW-1:0] in_word;

    // hold frame time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_frame_time <= '0;
        else if (i_cfg_we) r_frame_time <= i_cfg_wdata;
    end

    // carry tlast in the spare pad bit
    assign in_word = {s_axis_tdata[InDataW-1:365], s_axis_tlast, s_axis_tdata[363:0]};

    psu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_sts(sts), .o_cmd(cmd)
    );

    psu_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_frame_time(r_frame_time),
        .i_data(in_word), .i_cmd(cmd), .o_sts(sts), .o_data(m_axis_tdata)
    );

endmodule
